// ===== sv/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Sizes, operation and status codes, and the control word sent to each cell.
// ----------------------------------------------------------------------------
package bole_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 4;
   localparam int POS_W    = 6;
   localparam int STAT_W   = 3;
   localparam int LEN_W    = 7;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_HEAD  = 4'd0,
      MODE_REM_HEAD  = 4'd1,
      MODE_INS_TAIL  = 4'd2,
      MODE_REM_TAIL  = 4'd3,
      MODE_INS_POS   = 4'd4,
      MODE_DEL_POS   = 4'd5,
      MODE_INS_MATCH = 4'd6,
      MODE_DEL_MATCH = 4'd7,
      MODE_CLEAR     = 4'd8
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              capture;  // latch the compare against match
      logic              ins;      // open a slot at k
      logic              del;      // close the slot at k
      logic [IDX_W-1:0]  k;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] match;
   } cell_ctrl_type;

endpackage

// ===== sv/bole_cell.sv =====
// ----------------------------------------------------------------------------
// bole_cell: one storage cell of the list row
// Holds one entry, shifts toward either neighbor and compares against a key.
// ----------------------------------------------------------------------------
module bole_cell (
   input  logic                        clock,
   input  bole_pkg::cell_ctrl_type     ctrl,
   input  logic [bole_pkg::IDX_W-1:0]  cell_idx,
   input  logic [bole_pkg::DATA_W-1:0] left_data,
   input  logic [bole_pkg::DATA_W-1:0] right_data,
   output logic [bole_pkg::DATA_W-1:0] data,
   output logic                        hit
);

   logic [bole_pkg::DATA_W-1:0] data_ff, data_in;
   logic                        hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (cell_idx > ctrl.k) begin
            data_in = left_data;
         end else if (cell_idx == ctrl.k) begin
            data_in = ctrl.value;
         end
      end else if (ctrl.del && (cell_idx >= ctrl.k)) begin
         data_in = right_data;
      end
   end

   assign hit_in = ctrl.capture ? (data_ff == ctrl.match) : hit_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// ===== sv/bole_first.sv =====
// ----------------------------------------------------------------------------
// bole_first: first-hit encoder
// Finds the lowest cell index whose compare flag is set.
// ----------------------------------------------------------------------------
module bole_first (
   input  logic [bole_pkg::CAPACITY-1:0] hits,
   output logic                          found,
   output logic [bole_pkg::IDX_W-1:0]    first_idx
);

   always_comb begin
      first_idx = '0;
      for (int i = bole_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (hits[i]) begin
            first_idx = bole_pkg::IDX_W'(i);
         end
      end
   end

   assign found = |hits;

endmodule

// ===== sv/bounded_ordered_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top: ordered list of signed values in a cell row
// Head/tail/position/match insert and delete, clear; one response per request.
// ----------------------------------------------------------------------------
//   channel   dir   handshake              payload
//   req_      in    req_valid/req_ready    mode, value, position, match_value
//   rsp_      out   rsp_valid/rsp_ready    removed_value, status, length
//
// a request is latched in S_IDLE, where every cell compares its entry with
// match_value; in S_EXEC the first hit is picked and the row is shifted.
// a new request is taken while the previous response waits in the output
// register; S_EXEC holds while that register is full and not being read.
// reset clears the length and control; the entries themselves are not reset.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bole_pkg::MODE_W-1:0]  req_mode,
   input  logic signed [bole_pkg::DATA_W-1:0] req_value,
   input  logic [bole_pkg::POS_W-1:0]   req_position,
   input  logic signed [bole_pkg::DATA_W-1:0] req_match_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [bole_pkg::DATA_W-1:0] rsp_removed_value,
   output logic [bole_pkg::STAT_W-1:0]  rsp_status,
   output logic [bole_pkg::LEN_W-1:0]   rsp_length
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [bole_pkg::MODE_W-1:0] mode_ff;
   logic [bole_pkg::DATA_W-1:0] value_ff;
   logic [bole_pkg::POS_W-1:0]  pos_ff;
   logic [bole_pkg::CNT_W-1:0]  count_ff, count_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bole_pkg::DATA_W-1:0] rsp_removed_ff;
   logic [bole_pkg::STAT_W-1:0] rsp_status_ff;
   logic [bole_pkg::LEN_W-1:0]  rsp_length_ff;

   logic accept, go;
   logic act_ins, act_del, act_clr;
   logic [bole_pkg::IDX_W-1:0]  k_sel;
   logic [bole_pkg::DATA_W-1:0] removed;
   logic [bole_pkg::STAT_W-1:0] status;

   logic [bole_pkg::DATA_W-1:0]   cell_data [bole_pkg::CAPACITY];
   logic [bole_pkg::CAPACITY-1:0] cell_hit, live_hit;
   bole_pkg::cell_ctrl_type       ctrl;

   logic                       found;
   logic [bole_pkg::IDX_W-1:0] first_idx;

   logic full, empty, pos_ge;
   logic [bole_pkg::IDX_W-1:0] count_idx, last_idx, pos_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // ---------------- cell row ----------------
   assign ctrl.capture = accept;
   assign ctrl.ins     = go && act_ins;
   assign ctrl.del     = go && act_del;
   assign ctrl.k       = k_sel;
   assign ctrl.value   = value_ff;
   assign ctrl.match   = req_match_value;

   for (genvar i = 0; i < bole_pkg::CAPACITY; i++) begin : g_cell
      logic [bole_pkg::DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = cell_data[i];
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == bole_pkg::CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_inner
         assign right_d = cell_data[i+1];
      end

      bole_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_idx   (bole_pkg::IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );

      // only stored entries may match
      assign live_hit[i] = cell_hit[i] && (bole_pkg::CNT_W'(i) < count_ff);
   end

   bole_first u_first (
      .hits      (live_hit),
      .found     (found),
      .first_idx (first_idx)
   );

   // ---------------- operation decode ----------------
   assign full      = (count_ff == bole_pkg::CNT_W'(bole_pkg::CAPACITY));
   assign empty     = (count_ff == '0);
   assign pos_ge    = (bole_pkg::CMP_W'(pos_ff) >= bole_pkg::CMP_W'(count_ff));
   assign count_idx = bole_pkg::IDX_W'(count_ff);
   assign last_idx  = bole_pkg::IDX_W'(count_ff - bole_pkg::CNT_W'(1));
   assign pos_idx   = bole_pkg::IDX_W'(pos_ff);

   always_comb begin
      status  = bole_pkg::ST_OK;
      act_ins = 1'b0;
      act_del = 1'b0;
      act_clr = 1'b0;
      k_sel   = '0;
      unique case (mode_ff)
         bole_pkg::MODE_INS_HEAD: begin
            if (full) status = bole_pkg::ST_FULL;
            else act_ins = 1'b1;
         end
         bole_pkg::MODE_REM_HEAD: begin
            if (empty) status = bole_pkg::ST_EMPTY;
            else act_del = 1'b1;
         end
         bole_pkg::MODE_INS_TAIL: begin
            if (full) status = bole_pkg::ST_FULL;
            else begin
               act_ins = 1'b1;
               k_sel   = count_idx;
            end
         end
         bole_pkg::MODE_REM_TAIL: begin
            if (empty) status = bole_pkg::ST_EMPTY;
            else begin
               act_del = 1'b1;
               k_sel   = last_idx;
            end
         end
         bole_pkg::MODE_INS_POS: begin
            if (empty) begin
               if (pos_ff != '0) status = bole_pkg::ST_RANGE;
               else act_ins = 1'b1;
            end else if (pos_ge) begin
               status = bole_pkg::ST_RANGE;
            end else if (full) begin
               status = bole_pkg::ST_FULL;
            end else begin
               act_ins = 1'b1;
               k_sel   = pos_idx + bole_pkg::IDX_W'(1);
            end
         end
         bole_pkg::MODE_DEL_POS: begin
            if (empty) status = bole_pkg::ST_EMPTY;
            else if (pos_ge) status = bole_pkg::ST_RANGE;
            else begin
               act_del = 1'b1;
               k_sel   = pos_idx;
            end
         end
         bole_pkg::MODE_INS_MATCH: begin
            if (full) status = bole_pkg::ST_FULL;
            else if (empty) act_ins = 1'b1;
            else if (!found) status = bole_pkg::ST_NOTFOUND;
            else begin
               act_ins = 1'b1;
               k_sel   = first_idx + bole_pkg::IDX_W'(1);
            end
         end
         bole_pkg::MODE_DEL_MATCH: begin
            if (empty) status = bole_pkg::ST_EMPTY;
            else if (!found) status = bole_pkg::ST_NOTFOUND;
            else begin
               act_del = 1'b1;
               k_sel   = first_idx;
            end
         end
         bole_pkg::MODE_CLEAR: begin
            act_clr = 1'b1;
         end
         default: begin
            status = bole_pkg::ST_RANGE;
         end
      endcase
   end

   assign removed = act_del ? cell_data[k_sel] : '1;

   always_comb begin
      count_in = count_ff;
      if (go) begin
         if (act_clr) count_in = '0;
         else if (act_ins) count_in = count_ff + bole_pkg::CNT_W'(1);
         else if (act_del) count_in = count_ff - bole_pkg::CNT_W'(1);
      end
   end

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC:  if (go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (go) begin
         rsp_removed_ff <= removed;
         rsp_status_ff  <= status;
         rsp_length_ff  <= bole_pkg::LEN_W'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_length        = rsp_length_ff;

   // ---------------- checks ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bole_pkg::CNT_W'(bole_pkg::CAPACITY))
      else $error("list length above capacity");

   a_len_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (bole_pkg::CNT_W'(rsp_length_ff) == count_ff))
      else $error("response length differs from stored length");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while another is in flight");

   a_no_shift_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("length changed without an executing request");

endmodule

// ===== dv/ordered_list_checker.sv =====
// ----------------------------------------------------------------------------
// ordered_list_checker: response checker for the bounded ordered list engine
// Watches both channels, keeps its own copy of the stored list, works out the
// response each accepted request should give and compares the responses in order.
// ----------------------------------------------------------------------------
module ordered_list_checker
   import bole_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_match_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_removed_value,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic [LEN_W-1:0]         rsp_length,
   output int                       error_count,
   output int                       pending_count
);

   typedef struct packed {
      logic [DATA_W-1:0] removed;
      status_type        status;
      logic [LEN_W-1:0]  length;
   } list_result_t;

   logic [DATA_W-1:0] stored_values[$];
   list_result_t      pending_results[$];

   // index of the first entry equal to m, or the list length on a miss
   function automatic int first_match_index(input logic [DATA_W-1:0] m);
      int hit;
      hit = stored_values.size();
      for (int i = stored_values.size() - 1; i >= 0; i--) begin
         if (stored_values[i] == m) hit = i;
      end
      return hit;
   endfunction

   function automatic list_result_t apply_list_op(
      input logic [MODE_W-1:0] mode,
      input logic [DATA_W-1:0] value,
      input logic [POS_W-1:0]  position,
      input logic [DATA_W-1:0] match_value
   );
      list_result_t res;
      int           count;
      int           pos;
      int           hit;
      logic         full;
      count = stored_values.size();
      pos = int'(position);
      full = (count >= CAPACITY);
      res.removed = '1;
      res.status = ST_OK;
      case (mode_type'(mode))
         MODE_INS_HEAD: begin
            if (full) res.status = ST_FULL;
            else stored_values.push_front(value);
         end
         MODE_REM_HEAD: begin
            if (count == 0) res.status = ST_EMPTY;
            else res.removed = stored_values.pop_front();
         end
         MODE_INS_TAIL: begin
            if (full) res.status = ST_FULL;
            else stored_values.push_back(value);
         end
         MODE_REM_TAIL: begin
            if (count == 0) res.status = ST_EMPTY;
            else res.removed = stored_values.pop_back();
         end
         MODE_INS_POS: begin
            // empty list only takes position 0; range check wins over full
            if (count == 0) begin
               if (pos != 0) res.status = ST_RANGE;
               else stored_values.push_back(value);
            end else if (pos >= count) begin
               res.status = ST_RANGE;
            end else if (full) begin
               res.status = ST_FULL;
            end else begin
               stored_values.insert(pos + 1, value);
            end
         end
         MODE_DEL_POS: begin
            if (count == 0) begin
               res.status = ST_EMPTY;
            end else if (pos >= count) begin
               res.status = ST_RANGE;
            end else begin
               res.removed = stored_values[pos];
               stored_values.delete(pos);
            end
         end
         MODE_INS_MATCH: begin
            if (full) begin
               res.status = ST_FULL;
            end else if (count == 0) begin
               stored_values.push_back(value);
            end else begin
               hit = first_match_index(match_value);
               if (hit >= count) res.status = ST_NOTFOUND;
               else stored_values.insert(hit + 1, value);
            end
         end
         MODE_DEL_MATCH: begin
            if (count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               hit = first_match_index(match_value);
               if (hit >= count) begin
                  res.status = ST_NOTFOUND;
               end else begin
                  res.removed = stored_values[hit];
                  stored_values.delete(hit);
               end
            end
         end
         MODE_CLEAR: stored_values.delete();
         default: res.status = ST_RANGE;
      endcase
      res.length = LEN_W'(stored_values.size());
      return res;
   endfunction

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      list_result_t want;
      if (reset) begin
         stored_values.delete();
         pending_results.delete();
      end else begin
         // a response never belongs to the request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response: removed %0d status %0d length %0d",
                        $time, rsp_removed_value, rsp_status, rsp_length);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_removed_value !== want.removed) begin
                  $display("%0t: removed_value mismatch: expected %0d actual %0d",
                           $time, $signed(want.removed), rsp_removed_value);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               if (rsp_length !== want.length) begin
                  $display("%0t: length mismatch: expected %0d actual %0d",
                           $time, want.length, rsp_length);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(apply_list_op(req_mode, req_value, req_position,
                                                    req_match_value));
         end
      end
      pending_count = pending_results.size();
   end

endmodule

// ===== dv/bounded_ordered_list_engine_top_test.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top_test: testbench for the ordered list engine
// Directed corner requests, a fill to capacity, then random episodes that grow,
// shrink and mix the list, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_test;
   import bole_pkg::*;

   localparam int                CLEAR_CYCLES   = 9;
   localparam int                RANDOM_ITEMS   = 600;
   localparam int                IDLE_LIMIT     = 2000;
   localparam int                DRAIN_CYCLES   = 10;
   localparam int                HOLD_CYCLES    = 150;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode;
   logic signed [DATA_W-1:0] req_value;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_match_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic [STAT_W-1:0]        rsp_status;
   logic [LEN_W-1:0]         rsp_length;
   int                       error_count;
   int                       pending_count;

   logic [DATA_W-1:0] value_pool[8];
   int                burst_left;

   bounded_ordered_list_engine_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_position      (req_position),
      .req_match_value   (req_match_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length)
   );

   ordered_list_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_position      (req_position),
      .req_match_value   (req_match_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // drive a request at the falling edge and hold it until it is taken
   task automatic offer_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                                input logic [POS_W-1:0] position,
                                input logic [DATA_W-1:0] match_value);
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      req_position <= position;
      req_match_value <= match_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // bursts of back-to-back requests separated by random gaps
   task automatic paced_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                                input logic [POS_W-1:0] position,
                                input logic [DATA_W-1:0] match_value);
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) pause_requests($urandom_range(15, 30));
         else pause_requests($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      end
      burst_left--;
      offer_request(mode, value, position, match_value);
   endtask

   function automatic logic [MODE_W-1:0] pick_mode(input int insert_pct, input int clear_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 1) return MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      if (r < 1 + clear_pct) return MODE_CLEAR;
      if (r < 1 + clear_pct + insert_pct) begin
         case ($urandom_range(0, 3))
            0: return MODE_INS_HEAD;
            1: return MODE_INS_TAIL;
            2: return MODE_INS_POS;
            default: return MODE_INS_MATCH;
         endcase
      end
      case ($urandom_range(0, 3))
         0: return MODE_REM_HEAD;
         1: return MODE_REM_TAIL;
         2: return MODE_DEL_POS;
         default: return MODE_DEL_MATCH;
      endcase
   endfunction

   // a small pool of values so that value searches hit and duplicates occur
   function automatic logic [DATA_W-1:0] pick_value(input int pool_pct);
      if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 3));
      return POS_W'($urandom);
   endfunction

   // response side: its own stall pattern, plus two long hold-offs
   initial begin : rsp_pacing
      int cyc;
      int hold_left;
      rsp_ready = 1'b0;
      cyc = 0;
      hold_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 600 || cyc == 1700) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case ((cyc / 128) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= (cyc % 4) != 0;
               2: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= (cyc % 16) < 5;
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int episode_len;
      int insert_pct;
      int clear_pct;
      logic first_episode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_INS_HEAD;
      req_value = '0;
      req_position = '0;
      req_match_value = '0;
      burst_left = 0;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = '0;
      value_pool[3] = '1;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      repeat (CLEAR_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // removals on an empty list
      offer_request(MODE_REM_HEAD, 32'd5, 6'd0, 32'd0);
      offer_request(MODE_REM_TAIL, 32'd5, 6'd0, 32'd0);
      offer_request(MODE_DEL_POS, 32'd5, 6'd0, 32'd0);
      offer_request(MODE_DEL_MATCH, 32'd5, 6'd0, 32'd5);
      // insert after position on an empty list: only position 0 is taken
      offer_request(MODE_INS_POS, 32'h7fff_ffff, 6'd5, 32'd0);
      offer_request(MODE_INS_POS, 32'h7fff_ffff, 6'd0, 32'd0);
      offer_request(MODE_INS_MATCH, 32'd11, 6'd0, 32'd12345);
      offer_request(MODE_DEL_MATCH, 32'd0, 6'd0, 32'h8000_0000);
      offer_request(MODE_INS_HEAD, 32'h8000_0000, 6'd0, 32'd0);
      offer_request(MODE_INS_TAIL, 32'hffff_ffff, 6'd63, 32'hffff_ffff);
      offer_request(MODE_INS_MATCH, 32'd0, 6'd0, 32'h8000_0000);
      offer_request(MODE_INS_POS, 32'd42, 6'd63, 32'd0);
      offer_request(MODE_DEL_POS, 32'd0, 6'd63, 32'd0);
      offer_request(MODE_INS_POS, 32'h5555_aaaa, 6'd0, 32'd0);
      offer_request(MODE_DEL_POS, 32'd0, 6'd1, 32'd0);
      offer_request(MODE_DEL_MATCH, 32'd0, 6'd0, 32'hffff_ffff);
      offer_request(MODE_REM_TAIL, 32'd0, 6'd0, 32'd0);
      offer_request(MODE_REM_HEAD, 32'd0, 6'd0, 32'd0);
      offer_request(MODE_UNUSED_LO, 32'hffff_ffff, 6'h3f, 32'hffff_ffff);
      offer_request(MODE_UNUSED_HI, 32'd0, 6'd0, 32'd0);
      offer_request(MODE_CLEAR, 32'd0, 6'd0, 32'd0);
      offer_request(MODE_INS_MATCH, 32'd77, 6'd0, 32'd1);
      offer_request(MODE_CLEAR, 32'd0, 6'd0, 32'd0);

      // fill to capacity, then every insert must report full
      for (int i = 0; i < CAPACITY; i++) offer_request(MODE_INS_TAIL, $urandom, 6'd0, 32'd0);
      offer_request(MODE_INS_HEAD, 32'd1, 6'd0, 32'd0);
      offer_request(MODE_INS_TAIL, 32'd1, 6'd0, 32'd0);
      offer_request(MODE_INS_POS, 32'd1, 6'd63, 32'd0);
      offer_request(MODE_INS_MATCH, 32'd1, 6'd0, 32'd0);
      offer_request(MODE_DEL_POS, 32'd0, 6'd63, 32'd0);
      offer_request(MODE_CLEAR, 32'd0, 6'd0, 32'd0);

      // random episodes; the first always grows the list toward full
      sent = 0;
      first_episode = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         case (first_episode ? 0 : $urandom_range(0, 2))
            0: begin
               insert_pct = 90;
               clear_pct = 0;
               episode_len = $urandom_range(100, 140);
            end
            1: begin
               insert_pct = 20;
               clear_pct = 1;
               episode_len = $urandom_range(30, 80);
            end
            default: begin
               insert_pct = 50;
               clear_pct = 2;
               episode_len = $urandom_range(30, 80);
            end
         endcase
         first_episode = 1'b0;
         for (int i = 0; i < episode_len && sent < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(4, 7)] = $urandom;
            paced_request(pick_mode(insert_pct, clear_pct), pick_value(70), pick_position(),
                          pick_value(80));
            sent++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
